FILE: sv/wdfhf_pkg.sv
// shared constants, codes and helpers for the 802.11 data frame header filter
// no dependencies; used by the top level and its checker

package wdfhf_pkg;

    // widths fixed by the frame format
    localparam int LENGTH_BITS_DEF = 12;
    localparam int PREFIX_W        = 40;
    localparam int ADDR_W          = 48;
    localparam int PN_W            = 48;
    localparam int FC_W            = 16;
    localparam int SEQ_W           = 12;
    localparam int DIR_W           = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 40'h3c52a1fe39;

    // byte offsets in the header
    localparam int FC0_OFS      = 0;
    localparam int FC1_OFS      = 1;
    localparam int ADDR1_OFS    = 4;
    localparam int ADDR_STRIDE  = 6;
    localparam int NUM_ADDR     = 3;
    localparam int PREFIX_BYTES = 5;
    localparam int SA_OFS       = 10;
    localparam int ADDR_BYTES   = 6;
    localparam int SEQ_OFS      = 22;
    localparam int MIN_LEN      = 24;
    localparam int HDR_LEN      = 24;
    localparam int HDR_LEN_QOS  = 26;
    localparam int CCMP_LEN     = 8;
    localparam int PN_BYTES     = 6;

    // frame control fields
    localparam logic [7:0] FC0_TYPE_MASK    = 8'h0c;
    localparam logic [7:0] FC0_TYPE_DATA    = 8'h08;
    localparam logic [7:0] FC0_SUBTYPE_MASK = 8'hf0;
    localparam logic [7:0] FC0_QOS_DATA     = 8'h80;
    localparam logic [7:0] FC1_TO_DS        = 8'h01;
    localparam logic [7:0] FC1_FROM_DS      = 8'h02;
    localparam logic [7:0] FC1_PROTECTED    = 8'h40;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_UPLINK   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWNLINK = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NONE     = 2'd2;

    // byte k of the prefix, first byte in the top bits
    function automatic logic [7:0] prefix_byte(input logic [PREFIX_W-1:0] prefix,
                                               input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = prefix[39:32];
            3'd1:    b = prefix[31:24];
            3'd2:    b = prefix[23:16];
            3'd3:    b = prefix[15:8];
            3'd4:    b = prefix[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/wifi_data_frame_header_filter.sv
// 802.11 data frame header filter, top level
// depends on wdfhf_pkg

// Takes a received 802.11 frame one byte per word, starting at frame control,
// with last_byte marking the final byte. The frame length is counted and
// saturates at 2^LENGTH_BITS-1. A frame that is at least 24 bytes long, has
// type Data and has any of its three addresses starting with the 5-byte
// addr_prefix produces one result word after its last byte: length, frame
// control, sequence number, receiver group bit, source address, direction,
// QoS and Protected flags, and the CCMP packet number (zero when the frame is
// not protected or too short to hold the CCMP header). Other frames give no
// result. Throughput is one byte per cycle while in_stall is low: a byte
// goes through an input register and is then folded into the per-frame
// header state; a kept frame's result is then loaded into the output
// register. in_stall rises only when a last byte waits in the input
// register while the output register holds a result that is stalled.
// addr_prefix is written through cfg_valid/cfg_ready (always ready) and is
// meant to change only between frames.

module wifi_data_frame_header_filter #(
    parameter int LENGTH_BITS = wdfhf_pkg::LENGTH_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [wdfhf_pkg::PREFIX_W-1:0]            addr_prefix,
    // byte input
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [7:0]                                frame_byte,
    input  logic                                      last_byte,
    // result output
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [LENGTH_BITS-1:0]                    frame_length,
    output logic [wdfhf_pkg::FC_W-1:0]                frame_control,
    output logic [wdfhf_pkg::SEQ_W-1:0]               seq_number,
    output logic                                      receiver_group,
    output logic [wdfhf_pkg::ADDR_W-1:0]              source_address,
    output logic [wdfhf_pkg::DIR_W-1:0]               direction,
    output logic                                      qos_data,
    output logic                                      protected_frame,
    output logic [wdfhf_pkg::PN_W-1:0]                packet_number
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // configuration register
    logic [wdfhf_pkg::PREFIX_W-1:0] prefix_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // per-frame header state
    logic [LENGTH_BITS-1:0]          offset_reg,  offset_next;
    logic [wdfhf_pkg::FC_W-1:0]      fc_reg,      fc_next;
    logic [wdfhf_pkg::NUM_ADDR-1:0]  match_reg,   match_next;
    logic                            group_reg,   group_next;
    logic [wdfhf_pkg::ADDR_W-1:0]    sa_reg,      sa_next;
    logic [15:0]                     seq_reg,     seq_next;
    logic [wdfhf_pkg::PN_W-1:0]      pn_reg,      pn_next;

    // output register
    logic                            out_valid_reg;
    logic [LENGTH_BITS-1:0]          len_out_reg;
    logic [wdfhf_pkg::FC_W-1:0]      fc_out_reg;
    logic [wdfhf_pkg::SEQ_W-1:0]     seq_out_reg;
    logic                            group_out_reg;
    logic [wdfhf_pkg::ADDR_W-1:0]    sa_out_reg;
    logic [wdfhf_pkg::DIR_W-1:0]     dir_out_reg;
    logic                            qos_out_reg;
    logic                            prot_out_reg;
    logic [wdfhf_pkg::PN_W-1:0]      pn_out_reg;

    // handshake
    logic in_accept;
    logic out_free;
    logic s1_adv;
    logic result_load;

    // result terms
    logic [LENGTH_BITS-1:0]      hdr_len;
    logic [LENGTH_BITS-1:0]      hdr_len_next;
    logic [7:0]                  fc0_next;
    logic [7:0]                  fc1_next;
    logic                        qos_next;
    logic                        keep_frame;
    logic                        pn_present;
    logic [wdfhf_pkg::DIR_W-1:0] dir_next;

    // ------------------------------------------------------------------
    // handshake: the input register drains every cycle unless it holds a
    // last byte and the output register is full and stalled
    // ------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_adv      = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall    = s1_valid_reg && !s1_adv;
    assign in_accept   = in_valid && !in_stall;
    assign result_load = s1_adv && s1_last_reg && keep_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= wdfhf_pkg::PREFIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prefix_reg <= addr_prefix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= frame_byte;
            s1_last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // header capture by byte offset
    // ------------------------------------------------------------------

    // ccmp header start follows the subtype, known well before offset 24
    assign hdr_len = ((fc_reg[7:0] & wdfhf_pkg::FC0_SUBTYPE_MASK) == wdfhf_pkg::FC0_QOS_DATA)
                     ? LENGTH_BITS'(wdfhf_pkg::HDR_LEN_QOS)
                     : LENGTH_BITS'(wdfhf_pkg::HDR_LEN);

    always_comb
    begin
        logic [LENGTH_BITS-1:0] addr_base;
        logic [LENGTH_BITS-1:0] pn_ofs;
        logic [2:0]             k;

        fc_next    = fc_reg;
        match_next = match_reg;
        group_next = group_reg;
        sa_next    = sa_reg;
        seq_next   = seq_reg;
        pn_next    = pn_reg;

        if (offset_reg == LENGTH_BITS'(wdfhf_pkg::FC0_OFS))
        begin
            fc_next[7:0] = s1_byte_reg;
        end
        if (offset_reg == LENGTH_BITS'(wdfhf_pkg::FC1_OFS))
        begin
            fc_next[15:8] = s1_byte_reg;
        end
        if (offset_reg == LENGTH_BITS'(wdfhf_pkg::ADDR1_OFS))
        begin
            group_next = s1_byte_reg[0];
        end

        // prefix compare, one flag per address, cleared on first mismatch
        for (int a = 0; a < wdfhf_pkg::NUM_ADDR; a++)
        begin
            addr_base = LENGTH_BITS'(wdfhf_pkg::ADDR1_OFS + a * wdfhf_pkg::ADDR_STRIDE);
            k         = 3'(offset_reg - addr_base);
            if ((offset_reg >= addr_base)
                && (offset_reg < addr_base + LENGTH_BITS'(wdfhf_pkg::PREFIX_BYTES))
                && (wdfhf_pkg::prefix_byte(prefix_reg, k) != s1_byte_reg))
            begin
                match_next[a] = 1'b0;
            end
        end

        // source address, first byte on top
        for (int n = 0; n < wdfhf_pkg::ADDR_BYTES; n++)
        begin
            if (offset_reg == LENGTH_BITS'(wdfhf_pkg::SA_OFS + n))
            begin
                sa_next[8*(wdfhf_pkg::ADDR_BYTES-1-n) +: 8] = s1_byte_reg;
            end
        end

        if (offset_reg == LENGTH_BITS'(wdfhf_pkg::SEQ_OFS))
        begin
            seq_next[7:0] = s1_byte_reg;
        end
        if (offset_reg == LENGTH_BITS'(wdfhf_pkg::SEQ_OFS + 1))
        begin
            seq_next[15:8] = s1_byte_reg;
        end

        // pn0, pn1 then pn2..pn5 after the two reserved/key id bytes
        for (int n = 0; n < wdfhf_pkg::PN_BYTES; n++)
        begin
            pn_ofs = hdr_len + LENGTH_BITS'((n < 2) ? n : n + 2);
            if (offset_reg == pn_ofs)
            begin
                pn_next[8*(wdfhf_pkg::PN_BYTES-1-n) +: 8] = s1_byte_reg;
            end
        end
    end

    // saturating byte count, also the frame length on the last byte
    assign offset_next = (offset_reg != LEN_MAX) ? offset_reg + 1'b1 : LEN_MAX;

    // ------------------------------------------------------------------
    // end-of-frame decision and result fields
    // ------------------------------------------------------------------
    assign fc0_next     = fc_next[7:0];
    assign fc1_next     = fc_next[15:8];
    assign qos_next     = (fc0_next & wdfhf_pkg::FC0_SUBTYPE_MASK) == wdfhf_pkg::FC0_QOS_DATA;
    assign hdr_len_next = qos_next ? LENGTH_BITS'(wdfhf_pkg::HDR_LEN_QOS)
                                   : LENGTH_BITS'(wdfhf_pkg::HDR_LEN);
    assign keep_frame   = (offset_next >= LENGTH_BITS'(wdfhf_pkg::MIN_LEN))
                          && ((fc0_next & wdfhf_pkg::FC0_TYPE_MASK) == wdfhf_pkg::FC0_TYPE_DATA)
                          && (match_next != '0);
    assign pn_present   = ((fc1_next & wdfhf_pkg::FC1_PROTECTED) != 8'h00)
                          && (offset_next >= hdr_len_next + LENGTH_BITS'(wdfhf_pkg::CCMP_LEN));

    always_comb
    begin
        if ((fc1_next & wdfhf_pkg::FC1_TO_DS) != 8'h00)
        begin
            dir_next = wdfhf_pkg::DIR_UPLINK;
        end
        else if ((fc1_next & wdfhf_pkg::FC1_FROM_DS) != 8'h00)
        begin
            dir_next = wdfhf_pkg::DIR_DOWNLINK;
        end
        else
        begin
            dir_next = wdfhf_pkg::DIR_NONE;
        end
    end

    // per-frame state: updated on every byte, back to reset after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            fc_reg     <= '0;
            match_reg  <= '1;
            group_reg  <= 1'b0;
            sa_reg     <= '0;
            seq_reg    <= '0;
            pn_reg     <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                offset_reg <= '0;
                fc_reg     <= '0;
                match_reg  <= '1;
                group_reg  <= 1'b0;
                sa_reg     <= '0;
                seq_reg    <= '0;
                pn_reg     <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                fc_reg     <= fc_next;
                match_reg  <= match_next;
                group_reg  <= group_next;
                sa_reg     <= sa_next;
                seq_reg    <= seq_next;
                pn_reg     <= pn_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            len_out_reg   <= offset_next;
            fc_out_reg    <= fc_next;
            seq_out_reg   <= {seq_next[15:8], seq_next[7:4]};
            group_out_reg <= group_next;
            sa_out_reg    <= sa_next;
            dir_out_reg   <= dir_next;
            qos_out_reg   <= qos_next;
            prot_out_reg  <= (fc1_next & wdfhf_pkg::FC1_PROTECTED) != 8'h00;
            pn_out_reg    <= pn_present ? pn_next : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_length    = len_out_reg;
    assign frame_control   = fc_out_reg;
    assign seq_number      = seq_out_reg;
    assign receiver_group  = group_out_reg;
    assign source_address  = sa_out_reg;
    assign direction       = dir_out_reg;
    assign qos_data        = qos_out_reg;
    assign protected_frame = prot_out_reg;
    assign packet_number   = pn_out_reg;

endmodule

FILE: sv/wdfhf_checker.sv
// port-level checks for the 802.11 data frame header filter
// depends on wdfhf_pkg; bound to wifi_data_frame_header_filter

module wdfhf_checker #(
    parameter int LENGTH_BITS = wdfhf_pkg::LENGTH_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [LENGTH_BITS-1:0]           frame_length,
    input logic [wdfhf_pkg::DIR_W-1:0]      direction,
    input logic                             protected_frame,
    input logic [wdfhf_pkg::PN_W-1:0]       packet_number
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_length) && $stable(packet_number))
        else $error("result word changed while stalled");

    // only frames of at least MIN_LEN (24) bytes are reported
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_length >= LENGTH_BITS'(wdfhf_pkg::MIN_LEN))
        else $error("short frame reported");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction == wdfhf_pkg::DIR_UPLINK
                       || direction == wdfhf_pkg::DIR_DOWNLINK
                       || direction == wdfhf_pkg::DIR_NONE))
        else $error("bad direction code");

    // packet number only for protected frames
    a_pn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !protected_frame |-> packet_number == '0)
        else $error("packet number on unprotected frame");

endmodule

bind wifi_data_frame_header_filter wdfhf_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_wdfhf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_length    (frame_length),
    .direction       (direction),
    .protected_frame (protected_frame),
    .packet_number   (packet_number)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for wifi_data_frame_header_filter: frames go in one byte per word
// and each header result is checked against a local model; needs wdfhf_pkg and the block

module tb;

    localparam int LEN_BITS = wdfhf_pkg::LENGTH_BITS_DEF;
    localparam int LEN_MAX  = (1 << LEN_BITS) - 1;
    localparam int SETTLE   = 12;
    localparam logic [wdfhf_pkg::PREFIX_W-1:0] PREFIX_ONES = '1;

    // one expected result word
    typedef struct packed {
        logic [LEN_BITS-1:0]            len;
        logic [wdfhf_pkg::FC_W-1:0]     fc;
        logic [wdfhf_pkg::SEQ_W-1:0]    seq;
        logic                           grp;
        logic [wdfhf_pkg::ADDR_W-1:0]   sa;
        logic [wdfhf_pkg::DIR_W-1:0]    dir;
        logic                           qos;
        logic                           prot;
        logic [wdfhf_pkg::PN_W-1:0]     pn;
    } hdr_rec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_word_t;

    // how a directed frame is checked
    typedef enum logic [1:0] {
        EXP_MODEL,  // result as the model computes it
        EXP_DROP,   // no result at all
        EXP_LEN     // one result with the length typed in the table
    } row_check_e;

    typedef struct packed {
        logic [7:0]  fc0;
        logic [7:0]  fc1;
        logic [12:0] len;
        logic [2:0]  hits;      // addresses that carry the prefix
        row_check_e  check;
        logic [12:0] want_len;
    } frame_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_SPARSE} rx_mode_e;

    localparam int NUM_ROWS = 18;
    localparam frame_row_t DIRECTED [NUM_ROWS] = '{
        '{8'h08, 8'h00, 13'd24,   3'b001, EXP_LEN,   13'd24},   // shortest data frame after reset
        '{8'h08, 8'h01, 13'd23,   3'b111, EXP_DROP,  13'd0},    // one byte too short
        '{8'h00, 8'h02, 13'd30,   3'b111, EXP_DROP,  13'd0},    // management type
        '{8'h04, 8'h00, 13'd30,   3'b111, EXP_DROP,  13'd0},    // control type
        '{8'h0c, 8'h00, 13'd30,   3'b111, EXP_DROP,  13'd0},    // reserved type
        '{8'h08, 8'h00, 13'd30,   3'b000, EXP_DROP,  13'd0},    // no address matches
        '{8'h88, 8'h40, 13'd40,   3'b010, EXP_MODEL, 13'd0},    // protected qos data
        '{8'h88, 8'h41, 13'd33,   3'b100, EXP_MODEL, 13'd0},    // qos ccmp header one short
        '{8'h88, 8'h42, 13'd34,   3'b001, EXP_MODEL, 13'd0},    // qos ccmp header just fits
        '{8'h08, 8'h40, 13'd32,   3'b011, EXP_MODEL, 13'd0},    // ccmp header just fits
        '{8'h08, 8'h40, 13'd31,   3'b110, EXP_MODEL, 13'd0},    // ccmp header one short
        '{8'hf8, 8'h03, 13'd50,   3'b100, EXP_MODEL, 13'd0},    // both ds bits set
        '{8'h08, 8'hbc, 13'd28,   3'b111, EXP_MODEL, 13'd0},    // neither ds bit set
        '{8'hff, 8'hff, 13'd1,    3'b111, EXP_DROP,  13'd0},    // single byte frame
        '{8'h48, 8'h00, 13'd2,    3'b111, EXP_DROP,  13'd0},    // two byte frame
        '{8'h88, 8'hff, 13'd4095, 3'b111, EXP_LEN,   13'd4095}, // count reaches its top
        '{8'h88, 8'h40, 13'd4100, 3'b001, EXP_LEN,   13'd4095}, // count saturates
        '{8'h08, 8'h00, 13'd24,   3'b001, EXP_MODEL, 13'd0}     // state cleared after long frame
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [wdfhf_pkg::PREFIX_W-1:0]    addr_prefix = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [7:0]                        frame_byte = 8'h00;
    logic                              last_byte = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [LEN_BITS-1:0]               frame_length;
    logic [wdfhf_pkg::FC_W-1:0]        frame_control;
    logic [wdfhf_pkg::SEQ_W-1:0]       seq_number;
    logic                              receiver_group;
    logic [wdfhf_pkg::ADDR_W-1:0]      source_address;
    logic [wdfhf_pkg::DIR_W-1:0]       direction;
    logic                              qos_data;
    logic                              protected_frame;
    logic [wdfhf_pkg::PN_W-1:0]        packet_number;

    // local copy of the filter state
    logic [wdfhf_pkg::PREFIX_W-1:0]    pfx = wdfhf_pkg::PREFIX_RESET;
    logic [LEN_BITS-1:0]               ofs = '0;
    logic [15:0]                       fc_q = '0;
    logic [2:0]                        match_q = 3'b111;
    logic                              grp_q = 1'b0;
    logic [wdfhf_pkg::ADDR_W-1:0]      sa_q = '0;
    logic [15:0]                       seq_q = '0;
    logic [wdfhf_pkg::PN_W-1:0]        pn_q = '0;

    byte_word_t             tx_bytes[$];
    hdr_rec_t               pending_hdrs[$];
    int                     bytes_queued = 0;
    int                     bytes_taken = 0;
    int                     results_queued = 0;
    int                     fail_count = 0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     rx_left = 0;
    rx_mode_e               rx_mode = RX_OPEN;

    wifi_data_frame_header_filter #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .addr_prefix(addr_prefix),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_byte(frame_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_length(frame_length),
        .frame_control(frame_control),
        .seq_number(seq_number),
        .receiver_group(receiver_group),
        .source_address(source_address),
        .direction(direction),
        .qos_data(qos_data),
        .protected_frame(protected_frame),
        .packet_number(packet_number)
    );

    always #2 clk = ~clk;

    // folds one byte into the header state; returns 1 with the result on a kept last byte
    function automatic bit hdr_absorb(input logic [7:0] b, input logic last,
                                      output hdr_rec_t r);
        int  i;
        int  base;
        int  hl;
        int  rel;
        int  j;
        int  len;
        bit  keep;
        i = ofs;
        if (i == wdfhf_pkg::FC0_OFS)
            fc_q[7:0] = b;
        else if (i == wdfhf_pkg::FC1_OFS)
            fc_q[15:8] = b;
        if (i == wdfhf_pkg::ADDR1_OFS)
            grp_q = b[0];
        for (int a = 0; a < wdfhf_pkg::NUM_ADDR; a++)
        begin
            base = wdfhf_pkg::ADDR1_OFS + a * wdfhf_pkg::ADDR_STRIDE;
            if (i >= base && i < base + wdfhf_pkg::PREFIX_BYTES &&
                pfx[8 * (wdfhf_pkg::PREFIX_BYTES - 1 - (i - base)) +: 8] != b)
                match_q[a] = 1'b0;
        end
        if (i >= wdfhf_pkg::SA_OFS && i < wdfhf_pkg::SA_OFS + wdfhf_pkg::ADDR_BYTES)
            sa_q[8 * (wdfhf_pkg::SA_OFS + wdfhf_pkg::ADDR_BYTES - 1 - i) +: 8] = b;
        if (i == wdfhf_pkg::SEQ_OFS)
            seq_q[7:0] = b;
        else if (i == wdfhf_pkg::SEQ_OFS + 1)
            seq_q[15:8] = b;
        hl = ((fc_q[7:0] & wdfhf_pkg::FC0_SUBTYPE_MASK) == wdfhf_pkg::FC0_QOS_DATA)
             ? wdfhf_pkg::HDR_LEN_QOS : wdfhf_pkg::HDR_LEN;
        // pn0 pn1, two skipped bytes, then pn2..pn5
        if (i >= hl && i < hl + wdfhf_pkg::CCMP_LEN)
        begin
            rel = i - hl;
            if (rel < 2 || rel > 3)
            begin
                j = (rel < 2) ? rel : rel - 2;
                pn_q[8 * (wdfhf_pkg::PN_BYTES - 1 - j) +: 8] = b;
            end
        end
        len = (i < LEN_MAX) ? i + 1 : LEN_MAX;
        ofs = LEN_BITS'(len);
        r = '0;
        if (!last)
            return 1'b0;
        keep = len >= wdfhf_pkg::MIN_LEN
               && (fc_q[7:0] & wdfhf_pkg::FC0_TYPE_MASK) == wdfhf_pkg::FC0_TYPE_DATA
               && match_q != 0;
        if (keep)
        begin
            r.len  = LEN_BITS'(len);
            r.fc   = fc_q;
            r.seq  = {seq_q[15:8], seq_q[7:4]};
            r.grp  = grp_q;
            r.sa   = sa_q;
            if ((fc_q[15:8] & wdfhf_pkg::FC1_TO_DS) != 0)
                r.dir = wdfhf_pkg::DIR_UPLINK;
            else if ((fc_q[15:8] & wdfhf_pkg::FC1_FROM_DS) != 0)
                r.dir = wdfhf_pkg::DIR_DOWNLINK;
            else
                r.dir = wdfhf_pkg::DIR_NONE;
            r.qos  = (fc_q[7:0] & wdfhf_pkg::FC0_SUBTYPE_MASK) == wdfhf_pkg::FC0_QOS_DATA;
            r.prot = (fc_q[15:8] & wdfhf_pkg::FC1_PROTECTED) != 0;
            r.pn   = (r.prot && len >= hl + wdfhf_pkg::CCMP_LEN) ? pn_q : '0;
        end
        ofs = '0;
        fc_q = '0;
        match_q = 3'b111;
        grp_q = 1'b0;
        sa_q = '0;
        seq_q = '0;
        pn_q = '0;
        return keep;
    endfunction

    // builds a frame, queues its bytes and the result it should give
    function automatic void send_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                                       input int len, input logic [2:0] hits,
                                       input row_check_e check, input int want_len);
        logic [7:0] ab [wdfhf_pkg::NUM_ADDR][wdfhf_pkg::PREFIX_BYTES];
        byte_word_t w;
        hdr_rec_t   r;
        bit         hit;
        int         base;
        hit = 1'b0;
        for (int a = 0; a < wdfhf_pkg::NUM_ADDR; a++)
        begin
            for (int k = 0; k < wdfhf_pkg::PREFIX_BYTES; k++)
                ab[a][k] = pfx[8 * (wdfhf_pkg::PREFIX_BYTES - 1 - k) +: 8];
            // a miss is either one wrong byte or a random address
            if (!hits[a])
            begin
                if ($urandom_range(0, 1) != 0)
                    ab[a][$urandom_range(0, wdfhf_pkg::PREFIX_BYTES - 1)] ^=
                        8'($urandom_range(1, 255));
                else
                    for (int k = 0; k < wdfhf_pkg::PREFIX_BYTES; k++)
                        ab[a][k] = 8'($urandom);
            end
        end
        for (int i = 0; i < len; i++)
        begin
            w.data = 8'($urandom);
            if (i == wdfhf_pkg::FC0_OFS)
                w.data = fc0;
            else if (i == wdfhf_pkg::FC1_OFS)
                w.data = fc1;
            for (int a = 0; a < wdfhf_pkg::NUM_ADDR; a++)
            begin
                base = wdfhf_pkg::ADDR1_OFS + a * wdfhf_pkg::ADDR_STRIDE;
                if (i >= base && i < base + wdfhf_pkg::PREFIX_BYTES)
                    w.data = ab[a][i - base];
            end
            w.last = (i == len - 1);
            tx_bytes.push_back(w);
            bytes_queued++;
            hit = hdr_absorb(w.data, w.last, r);
        end
        case (check)
            EXP_DROP:
                ;
            EXP_LEN:
            begin
                r.len = LEN_BITS'(want_len);
                pending_hdrs.push_back(r);
                results_queued++;
            end
            default:
                if (hit)
                begin
                    pending_hdrs.push_back(r);
                    results_queued++;
                end
        endcase
    endfunction

    // mostly well-formed data frames with random content, some noise
    function automatic void send_random_frame();
        logic [7:0] fc0;
        logic [7:0] fc1;
        logic [2:0] hits;
        int         len;
        if ($urandom_range(0, 4) != 0)
        begin
            fc0 = {4'($urandom), 2'b10, 2'($urandom)};
            if ($urandom_range(0, 2) == 0)
                fc0[7:4] = 4'h8;
            hits = 3'($urandom_range(1, 7));
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, wdfhf_pkg::MIN_LEN - 1);
            else
                len = $urandom_range(wdfhf_pkg::MIN_LEN, 64);
        end
        else
        begin
            fc0 = 8'($urandom);
            hits = 3'($urandom);
            len = $urandom_range(1, 64);
        end
        fc1 = 8'($urandom);
        if ($urandom_range(0, 1) != 0)
            fc1 |= wdfhf_pkg::FC1_PROTECTED;
        send_frame(fc0, fc1, len, hits, EXP_MODEL, 0);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // waits until every byte is taken and every result has come, then lets the pipe empty
    task automatic settle();
        while (bytes_taken != bytes_queued || pending_hdrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_prefix(input logic [wdfhf_pkg::PREFIX_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        addr_prefix <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pfx = value;
    endtask

    // byte sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : byte_sender
        byte_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                bytes_taken++;
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    w = tx_bytes.pop_front();
                    frame_byte <= w.data;
                    last_byte <= w.last;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern switches between open, coin flip, pulses and rare stalls
    always @(posedge clk or negedge rst_n)
    begin : result_stall
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_OPEN:   out_stall <= 1'b0;
                RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
                RX_PULSE:  out_stall <= (rx_left % 12) < 7;
                default:   out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // compares each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        hdr_rec_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hdrs.size() == 0)
            begin
                $display("%0t: result with no expectation, expected none, got length %0d",
                         $time, frame_length);
                fail_count++;
            end
            else
            begin
                e = pending_hdrs.pop_front();
                check_field("frame_length", 64'(e.len), 64'(frame_length));
                check_field("frame_control", 64'(e.fc), 64'(frame_control));
                check_field("seq_number", 64'(e.seq), 64'(seq_number));
                check_field("receiver_group", 64'(e.grp), 64'(receiver_group));
                check_field("source_address", 64'(e.sa), 64'(source_address));
                check_field("direction", 64'(e.dir), 64'(direction));
                check_field("qos_data", 64'(e.qos), 64'(qos_data));
                check_field("protected_frame", 64'(e.prot), 64'(protected_frame));
                check_field("packet_number", 64'(e.pn), 64'(packet_number));
            end
        end
    end

    initial
    begin : run_limit
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [wdfhf_pkg::PREFIX_W-1:0] ph_pfx;
        int bytes0;
        int res0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset prefix
        for (int i = 0; i < NUM_ROWS; i++)
            send_frame(DIRECTED[i].fc0, DIRECTED[i].fc1, DIRECTED[i].len, DIRECTED[i].hits,
                       DIRECTED[i].check, DIRECTED[i].want_len);
        settle();

        // random frames, one prefix per phase
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       ph_pfx = '0;
                1:       ph_pfx = PREFIX_ONES;
                4:       ph_pfx = wdfhf_pkg::PREFIX_RESET;
                default: ph_pfx = {8'($urandom), 32'($urandom)};
            endcase
            write_prefix(ph_pfx);
            bytes0 = bytes_queued;
            res0 = results_queued;
            while (bytes_queued - bytes0 < 230 || results_queued - res0 < 10)
                send_random_frame();
            settle();
        end

        if (fail_count == 0 && pending_hdrs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: wifi_data_frame_header_filter.f
sv/wdfhf_pkg.sv
sv/wifi_data_frame_header_filter.sv
sv/wdfhf_checker.sv
tb/tb.sv
